@@ src/htsed_pkg.sv @@
// Shared types, entity tables and tag-name tables for the HTML text extractor.
package htsed_pkg;

   localparam int NumStages  = 9;
   localparam int MaxTagName = 16;
   localparam int NumBlock   = 23;

   typedef logic [9:0][7:0]  word_type;
   typedef logic [MaxTagName-1:0][7:0] name_type;
   typedef logic [7:0][7:0]  pat_type;
   typedef logic [2:0][7:0]  rep_type;

   // One token of the internal byte stream. The flush applies after the byte.
   typedef struct packed {
      logic       has_byte;
      logic       flush;
      logic [7:0] data;
   } tok_type;

   // Turns a right-aligned string literal into a byte array with char 0 at index 0.
   function automatic word_type to_word(input logic [79:0] lit, input logic [3:0] len);
      word_type w;
      int       pos;
      w = '0;
      for (int i = 0; i < 10; i++) begin
         pos = (i < int'(len)) ? (int'(len) - 1 - i) : 0;
         if (i < int'(len)) w[i] = lit[pos*8 +: 8];
      end
      return w;
   endfunction

   function automatic logic [2:0] ent_plen(input logic [3:0] s);
      logic [2:0] n;
      unique case (s)
         4'd0:    n = 3'd5;
         4'd1:    n = 3'd4;
         4'd2:    n = 3'd4;
         4'd3:    n = 3'd6;
         4'd4:    n = 3'd5;
         4'd5:    n = 3'd6;
         4'd6:    n = 3'd6;
         4'd7:    n = 3'd7;
         default: n = 3'd7;
      endcase
      return n;
   endfunction

   function automatic pat_type ent_pat(input logic [3:0] s);
      logic [79:0] lit;
      word_type    w;
      pat_type     p;
      unique case (s)
         4'd0:    lit = 80'("&amp;");
         4'd1:    lit = 80'("&lt;");
         4'd2:    lit = 80'("&gt;");
         4'd3:    lit = 80'("&quot;");
         4'd4:    lit = 80'("&#39;");
         4'd5:    lit = 80'("&nbsp;");
         4'd6:    lit = 80'("&apos;");
         4'd7:    lit = 80'("&mdash;");
         default: lit = 80'("&ndash;");
      endcase
      w = to_word(lit, {1'b0, ent_plen(s)});
      for (int i = 0; i < 8; i++) p[i] = w[i];
      return p;
   endfunction

   function automatic logic [1:0] ent_rlen(input logic [3:0] s);
      return (s >= 4'd7) ? 2'd3 : 2'd1;
   endfunction

   function automatic rep_type ent_rep(input logic [3:0] s);
      rep_type r;
      r = '0;
      unique case (s)
         4'd0:    r[0] = 8'h26;
         4'd1:    r[0] = 8'h3C;
         4'd2:    r[0] = 8'h3E;
         4'd3:    r[0] = 8'h22;
         4'd4:    r[0] = 8'h27;
         4'd5:    r[0] = 8'h20;
         4'd6:    r[0] = 8'h27;
         4'd7:    begin
            r[0] = 8'hE2; r[1] = 8'h80; r[2] = 8'h94;
         end
         default: begin
            r[0] = 8'hE2; r[1] = 8'h80; r[2] = 8'h93;
         end
      endcase
      return r;
   endfunction

   function automatic logic [3:0] block_len(input logic [4:0] k);
      logic [3:0] n;
      unique case (k)
         5'd0:                         n = 4'd1;
         5'd1, 5'd14:                  n = 4'd3;
         5'd13:                        n = 4'd10;
         5'd15, 5'd16:                 n = 4'd7;
         5'd17, 5'd18:                 n = 4'd6;
         5'd19:                        n = 4'd3;
         5'd20:                        n = 4'd4;
         default:                      n = 4'd2;
      endcase
      return n;
   endfunction

   function automatic word_type block_word(input logic [4:0] k);
      logic [79:0] lit;
      unique case (k)
         5'd0:    lit = 80'("p");
         5'd1:    lit = 80'("div");
         5'd2:    lit = 80'("br");
         5'd3:    lit = 80'("h1");
         5'd4:    lit = 80'("h2");
         5'd5:    lit = 80'("h3");
         5'd6:    lit = 80'("h4");
         5'd7:    lit = 80'("h5");
         5'd8:    lit = 80'("h6");
         5'd9:    lit = 80'("li");
         5'd10:   lit = 80'("tr");
         5'd11:   lit = 80'("td");
         5'd12:   lit = 80'("th");
         5'd13:   lit = 80'("blockquote");
         5'd14:   lit = 80'("pre");
         5'd15:   lit = 80'("section");
         5'd16:   lit = 80'("article");
         5'd17:   lit = 80'("header");
         5'd18:   lit = 80'("footer");
         5'd19:   lit = 80'("nav");
         5'd20:   lit = 80'("main");
         5'd21:   lit = 80'("ul");
         default: lit = 80'("ol");
      endcase
      return to_word(lit, block_len(k));
   endfunction

   // True when the stored name, starting at off, equals the word exactly.
   function automatic logic name_is(input name_type chars, input logic [4:0] len,
                                    input logic off, input word_type w,
                                    input logic [3:0] wlen);
      logic ok;
      ok = (len <= 5'(MaxTagName)) && (len >= {4'd0, off}) &&
           ((len - {4'd0, off}) == {1'b0, wlen});
      for (int i = 0; i < 10; i++) begin
         if (i < int'(wlen) && (i + int'(off)) < MaxTagName) begin
            if (chars[i + int'(off)] != w[i]) ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

@@ src/htsed_stage.sv @@
// One entity replacer stage: holds a pattern prefix and emits one byte per cycle while out_ready is high.
module htsed_stage
   import htsed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pat_type    pat,
   input  logic [2:0] pat_len,
   input  rep_type    rep,
   input  logic [1:0] rep_len,
   input  logic       in_valid,
   output logic       in_ready,
   input  tok_type    in_tok,
   output logic       out_valid,
   input  logic       out_ready,
   output tok_type    out_tok
);

   logic       tok_valid_ff, tok_valid_in;
   tok_type    tok_ff;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] match_ff, match_in;

   logic       hit, complete, extend, mism, addc, last_emit, done;
   logic [2:0] m_mid;
   logic [3:0] l1, lf, n, n_eff, rel;
   logic [7:0] c;

   always_comb begin
      c        = tok_ff.data;
      hit      = tok_ff.has_byte && (c == pat[match_ff]);
      complete = hit && ((match_ff + 3'd1) == pat_len);
      extend   = hit && !complete;
      mism     = tok_ff.has_byte && !hit;
      addc     = mism && (c != pat[0]);
      if (complete)    l1 = {2'd0, rep_len};
      else if (mism)   l1 = {1'b0, match_ff};
      else             l1 = 4'd0;
      if (complete)    m_mid = 3'd0;
      else if (extend) m_mid = match_ff + 3'd1;
      else if (mism)   m_mid = (c == pat[0]) ? 3'd1 : 3'd0;
      else             m_mid = match_ff;
      lf    = tok_ff.flush ? {1'b0, m_mid} : 4'd0;
      n     = l1 + {3'd0, addc} + lf;
      n_eff = (n == 4'd0 && tok_ff.flush) ? 4'd1 : n;

      // Output order: held prefix or replacement, then the byte, then the flushed prefix.
      rel = {1'b0, idx_ff} - l1 - {3'd0, addc};
      out_tok.has_byte = (n != 4'd0);
      out_tok.flush    = 1'b0;
      if ({1'b0, idx_ff} < l1)
         out_tok.data = complete ? rep[idx_ff[1:0]] : pat[idx_ff];
      else if (addc && ({1'b0, idx_ff} == l1))
         out_tok.data = c;
      else
         out_tok.data = pat[rel[2:0]];
      if (n == 4'd0) out_tok.data = 8'h00;

      last_emit     = ({1'b0, idx_ff} == (n_eff - 4'd1));
      out_tok.flush = tok_ff.flush && last_emit;
      out_valid     = tok_valid_ff && (n_eff != 4'd0);
      done          = tok_valid_ff && ((n_eff == 4'd0) || (out_ready && last_emit));
      in_ready      = !tok_valid_ff || done;

      tok_valid_in = tok_valid_ff;
      idx_in       = idx_ff;
      match_in     = match_ff;
      if (done) begin
         tok_valid_in = 1'b0;
         idx_in       = 3'd0;
         match_in     = tok_ff.flush ? 3'd0 : m_mid;
      end else if (out_valid && out_ready) begin
         idx_in = idx_ff + 3'd1;
      end
      if (in_valid && in_ready) tok_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
         match_ff     <= 3'd0;
      end else begin
         tok_valid_ff <= tok_valid_in;
         idx_ff       <= idx_in;
         match_ff     <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) tok_ff <= in_tok;
   end

endmodule

@@ src/html_tag_strip_entity_decode_unit.sv @@
// Top level of the HTML to plain text converter: tag parser, entity chain, result register.
//
//   channel | dir | payload
//   req     | in  | tdata = raw byte, tlast = final byte of the document
//   rsp     | out | tdata = text byte, tuser = byte present, tlast = end of text
//
// Plain text bytes pass at one byte per cycle and req is taken every cycle while
// the chain keeps moving. A byte whose entity prefix breaks, a replacement of
// several bytes, or the flush on tlast holds a stage until it has emitted all
// its bytes, and upstream stalls meanwhile. Reset clears the parser and all
// stage prefixes; rsp_tready low holds the result and backs up the chain.
module html_tag_strip_entity_decode_unit
   import htsed_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] byte_valid
   output logic       rsp_tlast
);

   logic       inside_ff, inside_in;
   logic       supp_ff, supp_in;
   name_type   chars_ff;
   logic [4:0] len_ff, len_in;
   logic       ended_ff, ended_in;
   logic [1:0] run_ff, run_in;

   logic       req_fire, closing, ss, blk, emit, keep, append, is_space;
   logic [7:0] c, tc, lc;
   tok_type    fe_tok;
   logic       fe_valid;

   logic    [NumStages:0] s_valid, s_ready;
   tok_type [NumStages:0] s_tok;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_user_ff, rsp_last_ff;
   logic       rsp_load;

   assign req_fire = req_tvalid && req_tready;
   assign req_tready = s_ready[0];

   always_comb begin
      c        = req_tdata;
      is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      lc       = (c >= "A" && c <= "Z") ? c + 8'h20 : c;
      closing  = (len_ff >= 5'd1) && (len_ff <= 5'(MaxTagName)) && (chars_ff[0] == "/");
      ss = name_is(chars_ff, len_ff, closing, to_word(80'("script"), 4'd6), 4'd6) ||
           name_is(chars_ff, len_ff, closing, to_word(80'("style"), 4'd5), 4'd5);
      blk = 1'b0;
      for (int k = 0; k < NumBlock; k++) begin
         if (name_is(chars_ff, len_ff, closing, block_word(5'(k)), block_len(5'(k))))
            blk = 1'b1;
      end

      inside_in = inside_ff;
      supp_in   = supp_ff;
      len_in    = len_ff;
      ended_in  = ended_ff;
      run_in    = run_ff;
      emit      = 1'b0;
      append    = 1'b0;
      tc        = c;

      if (inside_ff) begin
         if (c == ">") begin
            inside_in = 1'b0;
            if (ss) supp_in = !closing;
            if (blk) begin
               emit = 1'b1;
               tc   = 8'h0A;
            end
            len_in   = 5'd0;
            ended_in = 1'b0;
         end else if (!ended_ff) begin
            if (is_space) begin
               if (len_ff != 5'd0) ended_in = 1'b1;
            end else if (len_ff == 5'd0 || (c != "=" && c != 8'h22 && c != 8'h27)) begin
               append = 1'b1;
            end
         end
      end else if (c == "<") begin
         inside_in = 1'b1;
         len_in    = 5'd0;
         ended_in  = 1'b0;
      end else if (!supp_ff) begin
         emit = 1'b1;
      end

      if (append) len_in = (len_ff < 5'(MaxTagName)) ? len_ff + 5'd1 : 5'(MaxTagName + 1);

      // Newline runs collapse to two.
      keep = emit;
      if (emit) begin
         if (tc == 8'h0A) begin
            if (run_ff >= 2'd2) keep = 1'b0;
            else run_in = run_ff + 2'd1;
         end else begin
            run_in = 2'd0;
         end
      end

      if (req_tlast) begin
         inside_in = 1'b0;
         supp_in   = 1'b0;
         len_in    = 5'd0;
         ended_in  = 1'b0;
         run_in    = 2'd0;
      end

      fe_tok.has_byte = keep;
      fe_tok.flush    = req_tlast;
      fe_tok.data     = tc;
      fe_valid        = req_fire && (keep || req_tlast);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff <= 1'b0;
         supp_ff   <= 1'b0;
         len_ff    <= 5'd0;
         ended_ff  <= 1'b0;
         run_ff    <= 2'd0;
      end else if (req_fire) begin
         inside_ff <= inside_in;
         supp_ff   <= supp_in;
         len_ff    <= len_in;
         ended_ff  <= ended_in;
         run_ff    <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && append && len_ff < 5'(MaxTagName)) chars_ff[len_ff[3:0]] <= lc;
   end

   assign s_valid[0] = fe_valid;
   assign s_tok[0]   = fe_tok;

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      htsed_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .pat       (ent_pat(4'(s))),
         .pat_len   (ent_plen(4'(s))),
         .rep       (ent_rep(4'(s))),
         .rep_len   (ent_rlen(4'(s))),
         .in_valid  (s_valid[s]),
         .in_ready  (s_ready[s]),
         .in_tok    (s_tok[s]),
         .out_valid (s_valid[s+1]),
         .out_ready (s_ready[s+1]),
         .out_tok   (s_tok[s+1])
      );
   end

   assign s_ready[NumStages] = !rsp_valid_ff || rsp_tready;
   assign rsp_load = s_valid[NumStages] && s_ready[NumStages];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s_ready[NumStages]) begin
         rsp_valid_ff <= s_valid[NumStages];
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= s_tok[NumStages].has_byte ? s_tok[NumStages].data : 8'h00;
         rsp_user_ff <= s_tok[NumStages].has_byte;
         rsp_last_ff <= s_tok[NumStages].flush;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A transfer without a byte is only ever the bare end marker.
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata == 8'h00)
      else $error("bare result without end of text");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      run_ff != 2'd3)
      else $error("newline run counter overflow");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= 5'(MaxTagName + 1))
      else $error("tag name length out of range");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> !inside_ff && !supp_ff && len_ff == 5'd0)
      else $error("parser state not cleared after final byte");

endmodule
